>>> rtl/phr_pkg.sv
`default_nettype none

package phr_pkg;

	localparam int RADIUS_BITS_DEF = 10;
	localparam int RADIUS_RESET    = 255;

	localparam int ANGLE_W = 16;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd51470;

	localparam int LEVEL_W = 9;
	localparam logic [LEVEL_W-1:0] VALUE_ONE = 9'd256;

	// saturation, Q0.12 with one extra bit for 1.0
	localparam int SAT_FRAC = 12;
	localparam int SAT_W    = SAT_FRAC + 1;
	localparam logic [SAT_W-1:0] SAT_ONE = 13'd4096;

	// divider: quotient bits resolved per stage
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = SAT_FRAC / DIV_STEPS;

	// hue*6 = floor(angle * 15000 / 31415) by reciprocal and one correction
	localparam int HUE_MUL   = 15000;
	localparam int HUE_DIV   = 31415;
	localparam int HUE_SHIFT = 24;
	localparam int RECIP_W   = 23;
	localparam longint unsigned HUE_RECIP_L =
		(longint'(HUE_MUL) << HUE_SHIFT) / longint'(HUE_DIV);
	localparam logic [RECIP_W-1:0] HUE_RECIP = RECIP_W'(HUE_RECIP_L);
	localparam int HUE_W    = 15;
	localparam int HUE_FRAC = 12;

	localparam int HUE_STAGES   = 3;
	localparam int SHADE_STAGES = 3;

	localparam int LVL_W  = 33;
	localparam int PROD_W = 25;
	localparam logic [PROD_W-1:0] ONE_Q24 = 25'h100_0000;

	localparam int CHAN_W = 8;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LEVEL  = 1'd1;

	// hue sectors, red through yellow, green, cyan, blue, magenta
	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic [SAT_W-1:0]   sat;
		logic [LEVEL_W-1:0] value;
		logic [ANGLE_W-1:0] angle;
	} hue_in_t;

	typedef struct packed {
		logic [SAT_W-1:0]   sat;
		logic [LEVEL_W-1:0] value;
		logic [HUE_W-1:0]   h6;
	} shade_in_t;

	// floor(lvl * 255 / 2^32)
	function automatic logic [CHAN_W-1:0] to_byte(input logic [LVL_W-1:0] lvl);
		logic [LVL_W+CHAN_W-1:0] m;
		m = {lvl, CHAN_W'(0)} - {CHAN_W'(0), lvl};
		return m[LVL_W+CHAN_W-2 -: CHAN_W];
	endfunction

endpackage

`default_nettype wire

>>> rtl/phr_div_step.sv
`default_nettype none

module phr_div_step #(
	parameter int RADIUS_BITS = phr_pkg::RADIUS_BITS_DEF
) (
	input  wire logic [RADIUS_BITS-1:0]       divisor,
	input  wire logic [RADIUS_BITS-1:0]       rem_in,
	input  wire logic [phr_pkg::SAT_FRAC-1:0] quot_in,
	output logic      [RADIUS_BITS-1:0]       rem_out,
	output logic      [phr_pkg::SAT_FRAC-1:0] quot_out
);

	logic [RADIUS_BITS:0]           dbl;
	logic [RADIUS_BITS-1:0]         rem;
	logic [phr_pkg::SAT_FRAC-1:0]   quot;

	// restoring division, remainder stays below the divisor when rem_in starts below it
	always_comb begin
		rem  = rem_in;
		quot = quot_in;
		dbl  = '0;
		for (int i = 0; i < phr_pkg::DIV_STEPS; i++) begin
			dbl = {rem, 1'b0};
			if (dbl >= {1'b0, divisor}) begin
				dbl  = dbl - {1'b0, divisor};
				quot = {quot[phr_pkg::SAT_FRAC-2:0], 1'b1};
			end else begin
				quot = {quot[phr_pkg::SAT_FRAC-2:0], 1'b0};
			end
			rem = dbl[RADIUS_BITS-1:0];
		end
	end

	assign rem_out  = rem;
	assign quot_out = quot;

endmodule

`default_nettype wire

>>> rtl/phr_hue.sv
`default_nettype none

module phr_hue (
	input  wire logic                              clk,
	input  wire logic [phr_pkg::HUE_STAGES-1:0]    en,
	input  wire phr_pkg::hue_in_t                  hue_in,
	output phr_pkg::shade_in_t                     hue_out
);

	localparam int PRD_W = phr_pkg::ANGLE_W + phr_pkg::RECIP_W;
	localparam int NUM_W = 30;
	localparam int RES_W = 17;

	localparam logic [NUM_W-1:0] MUL_C = NUM_W'(phr_pkg::HUE_MUL);
	localparam logic [NUM_W-1:0] DIV_C = NUM_W'(phr_pkg::HUE_DIV);

	logic [PRD_W-1:0]             prod_s1;
	logic [phr_pkg::ANGLE_W-1:0]  angle_s1;
	logic [phr_pkg::SAT_W-1:0]    sat_s1;
	logic [phr_pkg::LEVEL_W-1:0]  value_s1;

	logic [phr_pkg::HUE_W-1:0]    qe_s2;
	logic [RES_W-1:0]             res_s2;
	logic [phr_pkg::SAT_W-1:0]    sat_s2;
	logic [phr_pkg::LEVEL_W-1:0]  value_s2;

	phr_pkg::shade_in_t           out_s3;

	logic [phr_pkg::HUE_W-1:0]    qe;
	logic [NUM_W-1:0]             num;
	logic [NUM_W-1:0]             den;
	logic [NUM_W-1:0]             diff;

	assign qe   = prod_s1[phr_pkg::HUE_SHIFT +: phr_pkg::HUE_W];
	assign num  = NUM_W'(angle_s1) * MUL_C;
	assign den  = NUM_W'(qe) * DIV_C;
	assign diff = num - den;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1  <= PRD_W'(hue_in.angle) * PRD_W'(phr_pkg::HUE_RECIP);
			angle_s1 <= hue_in.angle;
			sat_s1   <= hue_in.sat;
			value_s1 <= hue_in.value;
		end
		if (en[1]) begin
			qe_s2    <= qe;
			res_s2   <= diff[RES_W-1:0];
			sat_s2   <= sat_s1;
			value_s2 <= value_s1;
		end
		if (en[2]) begin
			// estimate is at most one short
			out_s3.h6    <= qe_s2 + phr_pkg::HUE_W'(res_s2 >= DIV_C[RES_W-1:0]);
			out_s3.sat   <= sat_s2;
			out_s3.value <= value_s2;
		end
	end

	assign hue_out = out_s3;

endmodule

`default_nettype wire

>>> rtl/phr_shade.sv
`default_nettype none

module phr_shade (
	input  wire logic                               clk,
	input  wire logic [phr_pkg::SHADE_STAGES-1:0]   en,
	input  wire phr_pkg::shade_in_t                 shade_in,
	output logic [3*phr_pkg::CHAN_W-1:0]            rgb
);

	localparam int VP_W = 21;

	logic [phr_pkg::HUE_FRAC-1:0]  frac;
	logic [phr_pkg::SAT_W-1:0]     frac_c;
	phr_pkg::sector_t              sector;

	logic [phr_pkg::PROD_W-1:0]    sf_s1;
	logic [phr_pkg::PROD_W-1:0]    sg_s1;
	logic [phr_pkg::SAT_W-1:0]     sp_s1;
	logic [phr_pkg::LEVEL_W-1:0]   value_s1;
	phr_pkg::sector_t              sector_s1;

	logic [VP_W-1:0]               vp;
	logic [phr_pkg::LVL_W-1:0]     lq_s2;
	logic [phr_pkg::LVL_W-1:0]     lt_s2;
	logic [phr_pkg::LVL_W-1:0]     lp_s2;
	logic [phr_pkg::LEVEL_W-1:0]   value_s2;
	phr_pkg::sector_t              sector_s2;

	logic [phr_pkg::CHAN_W-1:0]    bf;
	logic [phr_pkg::CHAN_W-1:0]    bq;
	logic [phr_pkg::CHAN_W-1:0]    bt;
	logic [phr_pkg::CHAN_W-1:0]    bp;
	logic [3*phr_pkg::CHAN_W-1:0]  mix;
	logic [3*phr_pkg::CHAN_W-1:0]  rgb_s3;

	assign frac   = shade_in.h6[phr_pkg::HUE_FRAC-1:0];
	assign frac_c = phr_pkg::SAT_ONE - {1'b0, frac};
	assign sector = phr_pkg::sector_t'(shade_in.h6[phr_pkg::HUE_W-1:phr_pkg::HUE_FRAC]);

	assign vp = VP_W'(value_s1) * VP_W'(sp_s1);

	assign bf = phr_pkg::to_byte({value_s2, 24'd0});
	assign bq = phr_pkg::to_byte(lq_s2);
	assign bt = phr_pkg::to_byte(lt_s2);
	assign bp = phr_pkg::to_byte(lp_s2);

	// blue, green, red from high to low
	always_comb begin
		case (sector_s2)
			phr_pkg::SEC_RY: mix = {bp, bt, bf};
			phr_pkg::SEC_YG: mix = {bp, bf, bq};
			phr_pkg::SEC_GC: mix = {bt, bf, bp};
			phr_pkg::SEC_CB: mix = {bf, bq, bp};
			phr_pkg::SEC_BM: mix = {bf, bp, bt};
			default:         mix = {bq, bp, bf};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sf_s1     <= phr_pkg::PROD_W'(shade_in.sat) * phr_pkg::PROD_W'(frac);
			sg_s1     <= phr_pkg::PROD_W'(shade_in.sat) * phr_pkg::PROD_W'(frac_c);
			sp_s1     <= phr_pkg::SAT_ONE - shade_in.sat;
			value_s1  <= shade_in.value;
			sector_s1 <= sector;
		end
		if (en[1]) begin
			lq_s2     <= phr_pkg::LVL_W'(value_s1) * phr_pkg::LVL_W'(phr_pkg::ONE_Q24 - sf_s1);
			lt_s2     <= phr_pkg::LVL_W'(value_s1) * phr_pkg::LVL_W'(phr_pkg::ONE_Q24 - sg_s1);
			lp_s2     <= {vp, 12'd0};
			value_s2  <= value_s1;
			sector_s2 <= sector_s1;
		end
		if (en[2]) begin
			rgb_s3 <= mix;
		end
	end

	assign rgb = rgb_s3;

endmodule

`default_nettype wire

>>> rtl/polar_hsv_to_rgb.sv
// Colour-wheel pixel generator: each item is a point given by radius and angle (Q3.13
// radians), and each result is its 8-bit red, green and blue after HSV to RGB conversion,
// with saturation = radius / wheel_radius capped at one and value = value_level (Q1.8).
// One item per clock while the output is not stalled; the pipeline depth is set by the
// input register, the six-stage saturation divider (two quotient bits a stage), the
// three-stage hue scaling and the three-stage level multiply and byte select.
// Back-pressure on the output stalls the stages that hold items while empty stages still
// fill. The user is to write configuration through cfg_wen/cfg_index/cfg_wdata only while
// no item is in flight; the block itself does not enforce this.
`default_nettype none

module polar_hsv_to_rgb #(
	parameter  int RADIUS_BITS = phr_pkg::RADIUS_BITS_DEF,
	localparam int S_TDATA_W   = ((RADIUS_BITS + phr_pkg::ANGLE_W + 7) / 8) * 8,
	localparam int CFG_W       = (RADIUS_BITS > phr_pkg::LEVEL_W) ? RADIUS_BITS
	                                                              : phr_pkg::LEVEL_W
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [S_TDATA_W-1:0]            s_tdata,   // point_radius, point_angle

	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [3*phr_pkg::CHAN_W-1:0]         m_tdata,   // red, green, blue

	input  wire logic                            cfg_wen,
	input  wire logic [phr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]                cfg_wdata
);

	localparam int N_STAGES = 1 + phr_pkg::DIV_STAGES + phr_pkg::HUE_STAGES
	                          + phr_pkg::SHADE_STAGES;
	localparam int HUE_BASE   = 1 + phr_pkg::DIV_STAGES;
	localparam int SHADE_BASE = HUE_BASE + phr_pkg::HUE_STAGES;

	typedef struct packed {
		logic [RADIUS_BITS-1:0]       rem;
		logic [phr_pkg::SAT_FRAC-1:0] quot;
		logic                         sat;
		logic                         nz;
		logic [phr_pkg::LEVEL_W-1:0]  value;
		logic [phr_pkg::ANGLE_W-1:0]  angle;
	} div_t;

	logic [RADIUS_BITS-1:0]       wheel_radius_q;
	logic [phr_pkg::LEVEL_W-1:0]  value_level_q;

	logic [N_STAGES-1:0]          vld_s;
	logic [N_STAGES-1:0]          en;

	logic [RADIUS_BITS-1:0]       radius;
	logic [phr_pkg::ANGLE_W-1:0]  angle;
	logic [phr_pkg::ANGLE_W-1:0]  angle_cl;
	logic [phr_pkg::LEVEL_W-1:0]  value_cl;

	div_t                         div_s [phr_pkg::DIV_STAGES+1];
	logic [RADIUS_BITS-1:0]       rem_nx  [1:phr_pkg::DIV_STAGES];
	logic [phr_pkg::SAT_FRAC-1:0] quot_nx [1:phr_pkg::DIV_STAGES];

	logic [phr_pkg::SAT_W-1:0]    sat_val;
	phr_pkg::hue_in_t             hue_in;
	phr_pkg::shade_in_t           shade_in;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q <= RADIUS_BITS'(phr_pkg::RADIUS_RESET);
			value_level_q  <= phr_pkg::VALUE_ONE;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				phr_pkg::CFG_WHEEL_RADIUS: wheel_radius_q <= cfg_wdata[RADIUS_BITS-1:0];
				phr_pkg::CFG_VALUE_LEVEL:  value_level_q  <= cfg_wdata[phr_pkg::LEVEL_W-1:0];
				default:                   value_level_q  <= value_level_q;
			endcase
		end
	end

	// stage enables, a stage moves when empty or when the next one moves
	always_comb begin
		en[N_STAGES-1] = !vld_s[N_STAGES-1] || m_tready;
		for (int k = N_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (en & {vld_s[N_STAGES-2:0], s_tvalid}) | (~en & vld_s);
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_s[N_STAGES-1];

	// input stage
	assign radius   = s_tdata[RADIUS_BITS-1:0];
	assign angle    = s_tdata[RADIUS_BITS +: phr_pkg::ANGLE_W];
	assign angle_cl = (angle > phr_pkg::ANGLE_MAX) ? phr_pkg::ANGLE_MAX : angle;
	assign value_cl = (value_level_q > phr_pkg::VALUE_ONE) ? phr_pkg::VALUE_ONE
	                                                      : value_level_q;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			div_s[0].rem   <= radius;
			div_s[0].quot  <= '0;
			div_s[0].sat   <= (radius >= wheel_radius_q) && (radius != '0);
			div_s[0].nz    <= (radius != '0);
			div_s[0].value <= value_cl;
			div_s[0].angle <= angle_cl;
		end
	end

	// saturation divider
	for (genvar k = 1; k <= phr_pkg::DIV_STAGES; k++) begin : g_div
		phr_div_step #(
			.RADIUS_BITS (RADIUS_BITS)
		) u_step (
			.divisor  (wheel_radius_q),
			.rem_in   (div_s[k-1].rem),
			.quot_in  (div_s[k-1].quot),
			.rem_out  (rem_nx[k]),
			.quot_out (quot_nx[k])
		);

		always_ff @(posedge clk) begin
			if (en[k]) begin
				div_s[k].rem   <= rem_nx[k];
				div_s[k].quot  <= quot_nx[k];
				div_s[k].sat   <= div_s[k-1].sat;
				div_s[k].nz    <= div_s[k-1].nz;
				div_s[k].value <= div_s[k-1].value;
				div_s[k].angle <= div_s[k-1].angle;
			end
		end
	end

	assign sat_val = div_s[phr_pkg::DIV_STAGES].sat ? phr_pkg::SAT_ONE
	               : div_s[phr_pkg::DIV_STAGES].nz  ? {1'b0, div_s[phr_pkg::DIV_STAGES].quot}
	               : '0;

	assign hue_in.sat   = sat_val;
	assign hue_in.value = div_s[phr_pkg::DIV_STAGES].value;
	assign hue_in.angle = div_s[phr_pkg::DIV_STAGES].angle;

	phr_hue u_hue (
		.clk     (clk),
		.en      (en[HUE_BASE +: phr_pkg::HUE_STAGES]),
		.hue_in  (hue_in),
		.hue_out (shade_in)
	);

	phr_shade u_shade (
		.clk      (clk),
		.en       (en[SHADE_BASE +: phr_pkg::SHADE_STAGES]),
		.shade_in (shade_in),
		.rgb      (m_tdata)
	);

endmodule

`default_nettype wire
